FILE: hdl/fadd_pkg.sv
// shared constants and types for the single-precision adder
`timescale 1ns / 1ps
`default_nettype none
package fadd_pkg;
  localparam logic [31:0] QNAN_OUT = 32'h7fffffff;
  localparam logic [31:0] POS_INF  = 32'h7f800000;
  localparam logic [31:0] NEG_INF  = 32'hff800000;
  localparam logic [7:0]  EXP_MAX  = 8'hff;
  localparam logic [7:0]  GAP_LIMIT = 8'd27;

  // control carried between pipeline stages
  typedef struct packed {
    logic        vld;
    logic        early;   // result already decided
    logic [31:0] early_val;
    logic        sign;
    logic        sub;
  } ctl_t;
endpackage
`default_nettype wire

FILE: hdl/float32_adder.sv
// single-precision adder, four-stage pipeline
//
// Usage: raise start with in_operand_a and in_operand_b for one cycle; the
// request is taken when busy is low. busy is tied low, so a new request can
// be taken in every cycle. After stage four, out_valid is high for
// one cycle with out_sum. Stage one unpacks, handles the special cases and
// orders the operands by magnitude; stage two aligns the smaller
// significand with a sticky bit; stage three adds or subtracts; stage four
// counts leading zeros, normalises, rounds to nearest even and packs.
// Throughput is one request per cycle. The receiver cannot stall the
// result: each result is shown for one cycle only. Reset clears the stage
// valid bits, so nothing leaves the block in the cycles after reset until a
// request is taken.
// Denormal operands are flushed; any NaN gives 0x7fffffff.
`timescale 1ns / 1ps
`default_nettype none
module float32_adder
  import fadd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  output logic [31:0]      out_sum
);
  assign busy = 1'b0;

  // stage 1
  ctl_t        c1_nxt, c1_r;
  logic [7:0]  ex1_nxt, ex1_r, d1_nxt, d1_r;
  logic [22:0] ma1_nxt, ma1_r, mb1_nxt, mb1_r;

  always_comb begin
    logic [31:0] a, b;
    logic nan_a, nan_b;
    a = in_operand_a;
    b = in_operand_b;
    nan_a = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    if (a[30:0] < b[30:0]) begin
      a = in_operand_b;
      b = in_operand_a;
    end
    c1_nxt.vld = start;
    c1_nxt.sign = a[31];
    c1_nxt.sub = a[31] ^ b[31];
    ex1_nxt = a[30:23];
    d1_nxt = a[30:23] - b[30:23];
    ma1_nxt = a[22:0];
    mb1_nxt = b[22:0];
    c1_nxt.early = 1'b1;
    c1_nxt.early_val = a;
    if (nan_a || nan_b) c1_nxt.early_val = QNAN_OUT;
    else if ((in_operand_a == POS_INF && in_operand_b == NEG_INF) ||
             (in_operand_b == POS_INF && in_operand_a == NEG_INF))
      c1_nxt.early_val = QNAN_OUT;
    else if (in_operand_a == POS_INF || in_operand_b == POS_INF)
      c1_nxt.early_val = POS_INF;
    else if (in_operand_a == NEG_INF || in_operand_b == NEG_INF)
      c1_nxt.early_val = NEG_INF;
    else if (in_operand_a[30:23] == 8'd0 && in_operand_b[30:23] == 8'd0)
      c1_nxt.early_val = 32'd0;
    else if (in_operand_a[30:23] == 8'd0) c1_nxt.early_val = in_operand_b;
    else if (in_operand_b[30:23] == 8'd0) c1_nxt.early_val = in_operand_a;
    else if (d1_nxt >= GAP_LIMIT) c1_nxt.early_val = a;
    else c1_nxt.early = 1'b0;
  end

  // stage 2: alignment with sticky
  ctl_t        c2_r;
  logic [7:0]  ex2_r;
  logic [26:0] ma2_r, mb2_r;
  logic [26:0] mb2_nxt;
  always_comb begin
    logic [26:0] mb, lost_mask;
    mb = {1'b1, mb1_r, 3'b000};
    lost_mask = ~(27'h7ffffff << d1_r[4:0]);
    mb2_nxt = (mb >> d1_r[4:0]) | {26'd0, |(mb & lost_mask)};
  end

  // stage 3: add or subtract
  ctl_t        c3_r;
  logic [7:0]  ex3_r;
  logic [27:0] m3_r;
  logic [27:0] m3_nxt;
  assign m3_nxt = c2_r.sub ? ({1'b0, ma2_r} - {1'b0, mb2_r})
                           : ({1'b0, ma2_r} + {1'b0, mb2_r});

  // stage 4: normalise, round, pack
  logic [31:0] res_nxt;
  always_comb begin
    logic [8:0]  ex;
    logic [27:0] m;
    logic [4:0]  lz;
    logic        found;
    ex = {1'b0, ex3_r};
    m = m3_r;
    lz = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        lz = 5'(26 - i);
      end
    end
    res_nxt = 32'd0;
    if (c3_r.early) res_nxt = c3_r.early_val;
    else if (m == 28'd0) res_nxt = 32'd0;
    else begin
      if (m[27]) begin
        ex = ex + 9'd1;
        m = (m >> 1) | {27'd0, m[0]};
      end else if ({4'd0, lz} >= ex) begin
        // exponent runs out before the leading one
        ex = 9'd0;
      end else begin
        ex = ex - {4'd0, lz};
        m = m << lz;
      end
      if (ex != 9'd0 && m[2] && (m[3] || m[1] || m[0])) begin
        m = m + 28'd8;
        if (m[27]) begin
          ex = ex + 9'd1;
          m = m >> 1;
        end
      end
      if (ex >= 9'd255) res_nxt = {c3_r.sign, POS_INF[30:0]};
      else if (ex == 9'd0) res_nxt = {c3_r.sign, 31'd0};
      else res_nxt = {c3_r.sign, ex[7:0], m[25:3]};
    end
  end

  logic        v4_r;
  logic [31:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.vld <= 1'b0;
      c2_r.vld <= 1'b0;
      c3_r.vld <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      c1_r.vld <= c1_nxt.vld;
      c2_r.vld <= c1_r.vld;
      c3_r.vld <= c2_r.vld;
      v4_r <= c3_r.vld;
    end
    c1_r.early <= c1_nxt.early;
    c1_r.early_val <= c1_nxt.early_val;
    c1_r.sign <= c1_nxt.sign;
    c1_r.sub <= c1_nxt.sub;
    ex1_r <= ex1_nxt;
    d1_r <= d1_nxt;
    ma1_r <= ma1_nxt;
    mb1_r <= mb1_nxt;
    c2_r.early <= c1_r.early;
    c2_r.early_val <= c1_r.early_val;
    c2_r.sign <= c1_r.sign;
    c2_r.sub <= c1_r.sub;
    ex2_r <= ex1_r;
    ma2_r <= {1'b1, ma1_r, 3'b000};
    mb2_r <= mb2_nxt;
    c3_r.early <= c2_r.early;
    c3_r.early_val <= c2_r.early_val;
    c3_r.sign <= c2_r.sign;
    c3_r.sub <= c2_r.sub;
    ex3_r <= ex2_r;
    m3_r <= m3_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = v4_r;
  assign out_sum = res_r;
endmodule
`default_nettype wire
